FILE: sv/atow_pkg.sv
// ----------------------------------------------------------------------------
// Asset table offset walker package
// Shared types and constants for the archive directory walker.
// ----------------------------------------------------------------------------
package atow_pkg;

   localparam int unsigned POS_W = 18;

   typedef logic [POS_W-1:0] pos_type;

   // Byte positions of the archive header fields.
   localparam pos_type POS_SIG_LO   = pos_type'(0);
   localparam pos_type POS_SIG_HI   = pos_type'(1);
   localparam pos_type POS_COUNT_LO = pos_type'(2);
   localparam pos_type POS_COUNT_HI = pos_type'(3);
   localparam pos_type POS_DIR_SIZE = pos_type'(4);
   localparam pos_type POS_DIR_LAST = pos_type'(7);
   localparam pos_type POS_SHORT    = pos_type'(8);

   localparam logic [15:0] SIG_A         = 16'h8004;
   localparam logic [15:0] SIG_B         = 16'h8005;
   localparam logic [17:0] HDR_BASE      = 18'd6;
   localparam logic [31:0] MIN_LENGTH    = 32'd4;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_SMALL = 2'd1,
      STATUS_BAD_SIG   = 2'd2,
      STATUS_OVERRUN   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_archive;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] entry_index;
      logic [31:0] entry_size;
      logic [31:0] entry_offset;
      logic        dir_flag;
      logic        last;
   } result_type;

endpackage

FILE: sv/atow_in_stage.sv
// ----------------------------------------------------------------------------
// Input stage
// Registers one request transaction and hands it to the walker core.
// ----------------------------------------------------------------------------
module atow_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_start_of_archive,
   input  logic              item_take,
   output logic              item_valid,
   output atow_pkg::item_type item
);

   logic                valid_ff;
   logic                valid_in;
   atow_pkg::item_type  item_ff;

   // The stage refills in the same cycle that the core consumes its item.
   assign req_ready = !valid_ff || item_take;

   always_comb begin
      valid_in = valid_ff;
      if (item_take) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff.data_byte        <= req_data_byte;
         item_ff.start_of_archive <= req_start_of_archive;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: sv/atow_core.sv
// ----------------------------------------------------------------------------
// Walker core
// Holds the parse state and the archive length, and decodes one byte per
// transaction into at most one entry record or error.
// ----------------------------------------------------------------------------
module atow_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [31:0]         csr_write_data,
   input  logic                fire,
   input  atow_pkg::item_type  item,
   output logic                res_valid,
   output atow_pkg::result_type res
);

   logic [31:0]       length_ff;
   atow_pkg::pos_type pos_ff, pos_e, pos_in;
   logic [7:0]        sig_lo_ff, sig_lo_e, sig_lo_in;
   logic [15:0]       total_ff, total_e, total_in;
   logic [31:0]       size_ff, size_e, size_in;
   logic [31:0]       roff_ff, roff_e, roff_in;
   logic [15:0]       next_ff, next_e, next_in;
   logic              fin_ff, fin_e, fin_in;

   logic [15:0]       sig_word;
   logic [15:0]       total_new;
   logic [17:0]       hdr;
   logic [31:0]       dir_word;
   logic              rep_go;
   logic [31:0]       rep_stored;
   logic [32:0]       end_sum;
   logic [16:0]       next_inc;
   logic              fail_go;
   atow_pkg::status_type fail_status;

   always_comb begin
      // A start marker restarts parsing before the byte is decoded.
      pos_e    = item.start_of_archive ? '0 : pos_ff;
      sig_lo_e = item.start_of_archive ? '0 : sig_lo_ff;
      total_e  = item.start_of_archive ? '0 : total_ff;
      size_e   = item.start_of_archive ? '0 : size_ff;
      roff_e   = item.start_of_archive ? '0 : roff_ff;
      next_e   = item.start_of_archive ? '0 : next_ff;
      fin_e    = item.start_of_archive ? 1'b0 : fin_ff;

      pos_in    = pos_e;
      sig_lo_in = sig_lo_e;
      total_in  = total_e;
      size_in   = size_e;
      roff_in   = roff_e;
      next_in   = next_e;
      fin_in    = fin_e;

      sig_word    = {item.data_byte, sig_lo_e};
      total_new   = {item.data_byte, total_e[7:0]};
      hdr         = atow_pkg::HDR_BASE + {1'b0, total_new, 1'b0};
      dir_word    = size_e | ({24'd0, item.data_byte} << {pos_e[1:0], 3'b000});
      rep_go      = 1'b0;
      rep_stored  = '0;
      fail_go     = 1'b0;
      fail_status = atow_pkg::STATUS_OK;

      if (!fin_e) begin
         pos_in = pos_e + atow_pkg::pos_type'(1);
         if (pos_e == atow_pkg::POS_SIG_LO) begin
            sig_lo_in = item.data_byte;
            if (length_ff < atow_pkg::MIN_LENGTH) begin
               fail_go     = 1'b1;
               fail_status = atow_pkg::STATUS_TOO_SMALL;
            end
         end else if (pos_e == atow_pkg::POS_SIG_HI) begin
            if (sig_word != atow_pkg::SIG_A && sig_word != atow_pkg::SIG_B) begin
               fail_go     = 1'b1;
               fail_status = atow_pkg::STATUS_BAD_SIG;
            end
         end else if (pos_e == atow_pkg::POS_COUNT_LO) begin
            total_in = {8'd0, item.data_byte};
         end else if (pos_e == atow_pkg::POS_COUNT_HI) begin
            total_in = total_new;
            if (total_new == '0 || {14'd0, hdr} > length_ff) begin
               fail_go     = 1'b1;
               fail_status = atow_pkg::STATUS_TOO_SMALL;
            end else begin
               roff_in = {14'd0, hdr};
            end
         end else if (pos_e < atow_pkg::POS_SHORT) begin
            // The directory entry has a four-byte little-endian size.
            size_in = dir_word;
            if (pos_e == atow_pkg::POS_DIR_LAST) begin
               rep_go     = 1'b1;
               rep_stored = dir_word;
            end
         end else if (!pos_e[0]) begin
            size_in = {24'd0, item.data_byte};
         end else begin
            rep_go     = 1'b1;
            rep_stored = {16'd0, item.data_byte, size_e[7:0]};
         end
      end

      end_sum  = {1'b0, roff_e} + {1'b0, rep_stored};
      next_inc = {1'b0, next_e} + 17'd1;

      res_valid        = fire && (rep_go || fail_go);
      res.status       = atow_pkg::STATUS_OK;
      res.entry_index  = '0;
      res.entry_size   = '0;
      res.entry_offset = '0;
      res.dir_flag     = 1'b0;
      res.last         = 1'b0;

      if (fail_go) begin
         fin_in     = 1'b1;
         res.status = fail_status;
         res.last   = 1'b1;
      end else if (rep_go) begin
         res.entry_index  = next_e;
         res.entry_size   = rep_stored;
         res.entry_offset = roff_e;
         res.dir_flag     = (next_e == '0);
         if (end_sum > {1'b0, length_ff}) begin
            res.status = atow_pkg::STATUS_OVERRUN;
            res.last   = 1'b1;
            fin_in     = 1'b1;
         end else begin
            roff_in  = end_sum[31:0];
            next_in  = next_inc[15:0];
            res.last = (next_inc >= {1'b0, total_e});
            fin_in   = res.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         pos_ff    <= '0;
         sig_lo_ff <= '0;
         total_ff  <= '0;
         size_ff   <= '0;
         roff_ff   <= '0;
         next_ff   <= '0;
         fin_ff    <= 1'b1;
      end else begin
         if (csr_write_enable) begin
            length_ff <= csr_write_data;
         end
         if (fire) begin
            pos_ff    <= pos_in;
            sig_lo_ff <= sig_lo_in;
            total_ff  <= total_in;
            size_ff   <= size_in;
            roff_ff   <= roff_in;
            next_ff   <= next_in;
            fin_ff    <= fin_in;
         end
      end
   end

endmodule

FILE: sv/atow_out_stage.sv
// ----------------------------------------------------------------------------
// Output stage
// Result register that holds one response transaction until it is taken.
// ----------------------------------------------------------------------------
module atow_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  atow_pkg::result_type res,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_entry_index,
   output logic [31:0]          rsp_entry_size,
   output logic [31:0]          rsp_entry_offset,
   output logic                 rsp_dir_flag,
   output logic                 rsp_last
);

   logic                 valid_ff;
   logic                 valid_in;
   atow_pkg::result_type res_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = res_ff.status;
   assign rsp_entry_index  = res_ff.entry_index;
   assign rsp_entry_size   = res_ff.entry_size;
   assign rsp_entry_offset = res_ff.entry_offset;
   assign rsp_dir_flag     = res_ff.dir_flag;
   assign rsp_last         = res_ff.last;

endmodule

FILE: sv/asset_table_offset_walker.sv
// Each byte is registered in the input stage, decoded by the core, and its result is
// registered in the output stage, which drives rsp_valid.
// Throughput: one byte per cycle unless a result waits untaken in the output stage.
// Reset: synchronous, active high; the archive length clears to zero and the
// walker stays idle, ignoring bytes, until a byte arrives with the start marker.
// ----------------------------------------------------------------------------
// Asset table offset walker
// Walks the directory of an asset archive byte by byte and reports the size
// and payload offset of every entry, or the error that ends the walk.
// ----------------------------------------------------------------------------
module asset_table_offset_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_archive,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_entry_index,
   output logic [31:0] rsp_entry_size,
   output logic [31:0] rsp_entry_offset,
   output logic        rsp_dir_flag,
   output logic        rsp_last
);

   logic                 item_valid;
   logic                 item_take;
   atow_pkg::item_type   item;
   logic                 res_valid;
   atow_pkg::result_type res;
   logic                 out_free;

   // A byte is decoded only when the result register can take its outcome.
   assign item_take = item_valid && out_free;

   atow_in_stage u_in_stage (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_start_of_archive (req_start_of_archive),
      .item_take            (item_take),
      .item_valid           (item_valid),
      .item                 (item)
   );

   atow_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fire             (item_take),
      .item             (item),
      .res_valid        (res_valid),
      .res              (res)
   );

   atow_out_stage u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .load             (res_valid),
      .res              (res),
      .free             (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_entry_size   (rsp_entry_size),
      .rsp_entry_offset (rsp_entry_offset),
      .rsp_dir_flag     (rsp_dir_flag),
      .rsp_last         (rsp_last)
   );

endmodule
